[rtl/text_to_unsigned_parser_top_defines.svh]
// Assertion macros for the text to unsigned parser checker.
`ifndef TEXT_TO_UNSIGNED_PARSER_TOP_DEFINES_SVH
`define TEXT_TO_UNSIGNED_PARSER_TOP_DEFINES_SVH

// Checked only outside reset.
`define TTU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ttu check failed");

// Checked at every edge, reset included.
`define TTU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ttu reset check failed");

`endif

[rtl/ttu_pkg.sv]
// Package: types, constants and digit decode for the text to unsigned parser.
`timescale 1ns / 1ps
`default_nettype none

package ttu_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_LEN_DEF    = 4096;
  localparam int END_W          = 13;
  localparam int BASE_W         = 6;
  localparam int DIG_W          = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [BASE_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_HEX  = 6'd16;

  localparam logic [DIG_W-1:0] DIGIT_NONE = 7'd99;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_SOME,
    DS_OVER
  } status_t;

  typedef struct packed {
    logic digits_found;
    logic overflowed;
  } flags_t;

  function automatic logic [DIG_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'(DIGIT_NONE);
      if (c inside {[CH_0:CH_9]}) d = c - CH_0;
      else if (c inside {[CH_UA:CH_UZ]}) d = c - CH_UA + 8'd10;
      else if (c inside {[CH_LA:CH_LZ]}) d = c - CH_LA + 8'd10;
      return DIG_W'(d);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/ttu_mac.sv]
// Multiply-add of the accumulator by the radix with overflow detect.
`timescale 1ns / 1ps
`default_nettype none

module ttu_mac #(
  parameter int VALUE_BITS = ttu_pkg::VALUE_BITS_DEF
) (
  input  wire logic [VALUE_BITS-1:0]     acc_in,
  input  wire logic [ttu_pkg::BASE_W-1:0] base,
  input  wire logic [ttu_pkg::DIG_W-1:0]  digit,
  output logic      [VALUE_BITS-1:0]     sum,
  output logic                           ovf
);
  import ttu_pkg::*;

  localparam int PW = VALUE_BITS + BASE_W + 1;

  logic [PW-1:0] full;

  assign full = PW'(acc_in) * PW'(base) + PW'(digit);
  assign sum  = full[VALUE_BITS-1:0];
  assign ovf  = |full[PW-1:VALUE_BITS];

endmodule

`default_nettype wire

[rtl/ttu_core.sv]
// Parse state and per-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

module ttu_core #(
  parameter int VALUE_BITS = ttu_pkg::VALUE_BITS_DEF,
  parameter int MAX_LEN    = ttu_pkg::MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step_en,
  input  wire logic [7:0]                 ch,
  input  wire logic                       start_req,
  input  wire logic [ttu_pkg::BASE_W-1:0] base_mode,
  output logic                            res_fire,
  output logic      [VALUE_BITS-1:0]      res_value,
  output logic      [ttu_pkg::END_W-1:0]  res_end,
  output ttu_pkg::flags_t                 res_flags
);
  import ttu_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);

  phase_t              phase, phase_next, e_phase;
  logic                negative, neg_next, e_neg;
  logic [VALUE_BITS-1:0] accumulator, acc_next, e_acc, dig_acc, mac_sum;
  status_t             digit_status, st_next, e_st, dig_st;
  logic [BASE_W-1:0]   working_base, wb_next, e_wb, dig_base, first_base;
  logic [POS_W-1:0]    position, pos_next, e_pos;
  logic [DIG_W-1:0]    digit;
  logic                digit_ok, zero_pfx, is_x, mac_ovf, digit_path;

  // a start request clears the state ahead of this byte
  assign e_phase = start_req ? PH_SKIP : phase;
  assign e_neg   = start_req ? 1'b0 : negative;
  assign e_acc   = start_req ? '0 : accumulator;
  assign e_st    = start_req ? DS_NONE : digit_status;
  assign e_wb    = start_req ? '0 : working_base;
  assign e_pos   = start_req ? '0 : position;

  assign digit      = digit_of(ch);
  assign is_x       = (ch == CH_LX) || (ch == CH_UX);
  assign zero_pfx   = ((base_mode == RADIX_AUTO) || (base_mode == RADIX_HEX)) && (ch == CH_0);
  assign first_base = (base_mode == RADIX_AUTO) ? RADIX_DEC : base_mode;

  always_comb begin
    case (e_phase)
      PH_SKIP, PH_SIGNED: dig_base = first_base;
      PH_ZERO:            dig_base = (base_mode == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
      PH_HEXPFX:          dig_base = RADIX_HEX;
      default:            dig_base = e_wb;
    endcase
  end

  // leading zero counts as a digit already taken
  assign dig_acc  = (e_phase == PH_ZERO) ? '0 : e_acc;
  assign dig_st   = (e_phase == PH_ZERO) ? DS_SOME : e_st;
  assign digit_ok = DIG_W'(dig_base) > digit;

  ttu_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
    .acc_in (dig_acc),
    .base   (dig_base),
    .digit  (digit),
    .sum    (mac_sum),
    .ovf    (mac_ovf)
  );

  always_comb begin
    phase_next = e_phase;
    case (e_phase)
      PH_IDLE:   phase_next = PH_IDLE;
      PH_SKIP: begin
        if (ch == CH_SPACE)                          phase_next = PH_SKIP;
        else if (ch == CH_MINUS || ch == CH_PLUS)    phase_next = PH_SIGNED;
        else if (zero_pfx)                           phase_next = PH_ZERO;
        else                                         phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_SIGNED: begin
        if (zero_pfx) phase_next = PH_ZERO;
        else          phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_ZERO: begin
        if (is_x) phase_next = PH_HEXPFX;
        else      phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_HEXPFX, PH_DIGITS: phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    neg_next   = e_neg;
    acc_next   = e_acc;
    st_next    = e_st;
    wb_next    = e_wb;
    digit_path = 1'b0;
    res_fire   = 1'b0;
    case (e_phase)
      PH_SKIP: begin
        if (ch == CH_MINUS) neg_next = 1'b1;
        else if (ch != CH_SPACE && ch != CH_PLUS && !zero_pfx) begin
          digit_path = 1'b1;
          wb_next    = dig_base;
        end
      end
      PH_SIGNED: begin
        if (!zero_pfx) begin
          digit_path = 1'b1;
          wb_next    = dig_base;
        end
      end
      PH_ZERO: begin
        if (!is_x) begin
          digit_path = 1'b1;
          wb_next    = dig_base;
        end
      end
      PH_HEXPFX: begin
        digit_path = 1'b1;
        wb_next    = dig_base;
      end
      PH_DIGITS: digit_path = 1'b1;
      default:   digit_path = 1'b0;
    endcase
    if (digit_path) begin
      acc_next = dig_acc;
      st_next  = dig_st;
      if (!digit_ok) begin
        res_fire = 1'b1;
      end else if (dig_st != DS_OVER) begin
        if (mac_ovf) begin
          st_next  = DS_OVER;
          acc_next = '1;
        end else begin
          st_next  = DS_SOME;
          acc_next = mac_sum;
        end
      end
    end
  end

  always_comb begin
    if (e_phase == PH_IDLE) pos_next = e_pos;
    else if (e_pos < POS_W'(MAX_LEN)) pos_next = e_pos + POS_W'(1);
    else pos_next = e_pos;
  end

  assign res_value              = (e_neg && dig_st == DS_SOME) ? (~dig_acc + VALUE_BITS'(1))
                                                               : dig_acc;
  assign res_flags.digits_found = dig_st != DS_NONE;
  assign res_flags.overflowed   = dig_st == DS_OVER;
  assign res_end                = (dig_st != DS_NONE) ? END_W'(e_pos) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      negative     <= 1'b0;
      accumulator  <= '0;
      digit_status <= DS_NONE;
      working_base <= '0;
      position     <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      negative     <= neg_next;
      accumulator  <= acc_next;
      digit_status <= st_next;
      working_base <= wb_next;
      position     <= pos_next;
    end
  end

endmodule

`default_nettype wire

[rtl/text_to_unsigned_parser_top.sv]
// Top level: input register, parse core, result register, radix register.
//
//   port group       dir   handshake              payload
//   input byte       in    in_valid / in_ready     ch, start_req
//   result           out   out_valid / out_ready   value, end_index, digits_found, overflowed
//   radix register   in    base_mode_we            base_mode_wdata
//
// One byte per cycle unless a held result stalls; out_valid is set by the closing byte.
// The parse step (decode, 64x6 multiply-add, overflow test) sits between the input
// register and the result register. A result held by out_ready low stalls the step
// stage, and in_ready drops once the input register is also full.
// Synchronous reset returns to idle with radix 0 (automatic).
`timescale 1ns / 1ps
`default_nettype none

module text_to_unsigned_parser_top #(
  parameter int VALUE_BITS = ttu_pkg::VALUE_BITS_DEF,
  parameter int MAX_LEN    = ttu_pkg::MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       base_mode_we,
  input  wire logic [ttu_pkg::BASE_W-1:0] base_mode_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 ch,
  input  wire logic                       start_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [VALUE_BITS-1:0]      value,
  output logic      [ttu_pkg::END_W-1:0]  end_index,
  output logic                            digits_found,
  output logic                            overflowed
);
  import ttu_pkg::*;

  logic [BASE_W-1:0]     base_mode;
  logic                  in_q_valid;
  logic [7:0]            ch_q;
  logic                  start_q;
  logic                  advance;
  logic                  res_fire;
  logic [VALUE_BITS-1:0] res_value;
  logic [END_W-1:0]      res_end;
  flags_t                res_flags;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode <= RADIX_AUTO;
    end else if (base_mode_we) begin
      base_mode <= base_mode_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q    <= ch;
      start_q <= start_req;
    end
  end

  ttu_core #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .ch        (ch_q),
    .start_req (start_q),
    .base_mode (base_mode),
    .res_fire  (res_fire),
    .res_value (res_value),
    .res_end   (res_end),
    .res_flags (res_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      value        <= res_value;
      end_index    <= res_end;
      digits_found <= res_flags.digits_found;
      overflowed   <= res_flags.overflowed;
    end
  end

endmodule

`default_nettype wire

[rtl/ttu_checker.sv]
// Port-level checks for the text to unsigned parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "text_to_unsigned_parser_top_defines.svh"

module ttu_checker #(
  parameter int VALUE_BITS = ttu_pkg::VALUE_BITS_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [VALUE_BITS-1:0]     value,
  input wire logic [ttu_pkg::END_W-1:0] end_index,
  input wire logic                      digits_found,
  input wire logic                      overflowed
);
  import ttu_pkg::*;

  `TTU_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid)
  `TTU_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(value)))
  `TTU_ASSERT(a_empty_parse, (out_valid && !digits_found) |-> (value == '0 && end_index == '0 && !overflowed))
  `TTU_ASSERT(a_saturate, (out_valid && overflowed) |-> (digits_found && value == '1 && end_index != '0))

endmodule

bind text_to_unsigned_parser_top ttu_checker #(.VALUE_BITS(VALUE_BITS)) u_ttu_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .value        (value),
  .end_index    (end_index),
  .digits_found (digits_found),
  .overflowed   (overflowed)
);

`default_nettype wire
